@@ rtl/spr_crc8_pkg.sv @@
// Package for the clocked serial packet receiver: phase and status codes,
// result type, register indexes and the reflected CRC-8 (0x8C) step.
// No dependencies.
package spr_crc8_pkg;

   localparam int MAX_BYTES = 32;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_ACCEPT = 2'd1,
      PH_RISE   = 2'd2,
      PH_FALL   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_ACCEPT_TIMEOUT = 3'd1,
      ST_BYTE_TIMEOUT   = 3'd2,
      ST_TOO_SHORT      = 3'd3,
      ST_CRC_MISMATCH   = 3'd4,
      ST_TOO_LONG       = 3'd5
   } status_type;

   // register index, taken from paddr[2]
   localparam logic CSR_ACCEPT_TIMEOUT = 1'b0;
   localparam logic CSR_BIT_TIMEOUT    = 1'b1;

   localparam logic [15:0] ACCEPT_TIMEOUT_RESET = 16'd5000;
   localparam logic [15:0] BIT_TIMEOUT_RESET    = 16'd200;

   typedef struct packed {
      logic       drive_data;
      logic       byte_valid;
      logic [7:0] byte_value;
      logic       packet_done;
      status_type status;
      logic [4:0] payload_length;
   } rsp_type;

   // contribution of each bit of (crc ^ byte) to the next crc value
   localparam logic [7:0] CRC_BITS [8] = '{
      8'h5e, 8'hbc, 8'h61, 8'hc2, 8'h9d, 8'h23, 8'h46, 8'h8c
   };

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] x;
      logic [7:0] r;
      x = crc ^ b;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (x[i]) r = r ^ CRC_BITS[i];
      end
      return r;
   endfunction

endpackage

@@ rtl/serial_packet_receiver_crc8_top.sv @@
// Top level of the clocked serial packet receiver with CRC-8 check.
// Depends on spr_crc8_pkg.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   request  | req_valid, req_stall, req_clock_level,   | in
//            | req_data_level                           |
//   response | rsp_valid, rsp_stall, rsp_drive_data ... | out
//   csr      | csr_psel/penable/pwrite/paddr/pwdata,    | in/out
//            | csr_prdata, csr_pready                   |
//
// One request (one line sample) per cycle while req_stall is low; its response
// is registered (in the skid entry while the output is held). The receive state
// advances in the accepting cycle, so back-to-back requests run at full rate.
// A two-entry output (register plus skid) lets one more request in while the
// response side stalls; req_stall is high only when the skid entry is full.
// Synchronous reset returns to idle and loads the timeout defaults.
module serial_packet_receiver_crc8_top
   import spr_crc8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_clock_level,
   input  logic        req_data_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_drive_data,
   output logic        rsp_byte_valid,
   output logic [7:0]  rsp_byte_value,
   output logic        rsp_packet_done,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_payload_length,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0] accept_timeout_ff;
   logic [15:0] bit_timeout_ff;

   phase_type   phase_ff, phase_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic [2:0]  bit_index_ff, bit_index_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [5:0]  byte_total_ff, byte_total_in;
   logic [7:0]  crc_all_ff, crc_all_in;
   logic [7:0]  crc_before_last_ff, crc_before_last_in;

   rsp_type     result;
   rsp_type     out_ff;
   rsp_type     skid_ff;
   logic        out_valid_ff;
   logic        skid_valid_ff;

   logic        req_accept;
   logic        rsp_take;
   logic        csr_write;
   logic [16:0] tick_next;
   logic [5:0]  byte_total_inc;
   logic [5:0]  payload_count;

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         accept_timeout_ff <= ACCEPT_TIMEOUT_RESET;
         bit_timeout_ff    <= BIT_TIMEOUT_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == CSR_ACCEPT_TIMEOUT) accept_timeout_ff <= csr_pwdata[15:0];
         if (csr_paddr[2] == CSR_BIT_TIMEOUT)    bit_timeout_ff    <= csr_pwdata[15:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == CSR_BIT_TIMEOUT) csr_prdata = {16'd0, bit_timeout_ff};
      else                                 csr_prdata = {16'd0, accept_timeout_ff};
   end

   // ---------------- handshake ----------------
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_take   = out_valid_ff && !rsp_stall;

   // ---------------- receive step ----------------
   always_comb begin
      phase_in           = phase_ff;
      tick_count_in      = tick_count_ff;
      bit_index_in       = bit_index_ff;
      shift_byte_in      = shift_byte_ff;
      byte_total_in      = byte_total_ff;
      crc_all_in         = crc_all_ff;
      crc_before_last_in = crc_before_last_ff;
      result             = '0;
      tick_next          = {1'b0, tick_count_ff} + 17'd1;
      byte_total_inc     = byte_total_ff + 6'd1;
      payload_count      = byte_total_ff - 6'd1;

      case (phase_ff)
         PH_IDLE: begin
            if (req_clock_level) begin
               phase_in           = PH_ACCEPT;
               tick_count_in      = '0;
               bit_index_in       = '0;
               shift_byte_in      = '0;
               byte_total_in      = '0;
               crc_all_in         = '0;
               crc_before_last_in = '0;
            end
         end
         PH_ACCEPT: begin
            if (!req_clock_level) begin
               phase_in      = PH_RISE;
               tick_count_in = '0;
            end else if (tick_next >= {1'b0, accept_timeout_ff}) begin
               phase_in           = PH_IDLE;
               result.packet_done = 1'b1;
               result.status      = ST_ACCEPT_TIMEOUT;
            end else begin
               tick_count_in = tick_next[15:0];
            end
         end
         PH_RISE: begin
            if (req_clock_level) begin
               if (bit_index_ff == 3'd0) shift_byte_in = {7'd0, req_data_level};
               else shift_byte_in = shift_byte_ff | ({7'd0, req_data_level} << bit_index_ff);
               phase_in      = PH_FALL;
               tick_count_in = '0;
            end else if (tick_next >= {1'b0, bit_timeout_ff}) begin
               phase_in           = PH_IDLE;
               result.packet_done = 1'b1;
               // timeout at a byte boundary closes the packet
               if (bit_index_ff != 3'd0)          result.status = ST_BYTE_TIMEOUT;
               else if (byte_total_ff < 6'd2)     result.status = ST_TOO_SHORT;
               else if (shift_byte_ff != crc_before_last_ff) result.status = ST_CRC_MISMATCH;
               else begin
                  result.status = ST_OK;
                  result.payload_length = (payload_count > 6'd31) ? 5'd31
                                                                  : payload_count[4:0];
               end
            end else begin
               tick_count_in = tick_next[15:0];
            end
         end
         PH_FALL: begin
            if (!req_clock_level) begin
               tick_count_in = '0;
               phase_in      = PH_RISE;
               if (bit_index_ff == 3'd7) begin
                  bit_index_in       = '0;
                  result.byte_valid  = 1'b1;
                  result.byte_value  = shift_byte_ff;
                  crc_before_last_in = crc_all_ff;
                  crc_all_in         = crc8_step(crc_all_ff, shift_byte_ff);
                  byte_total_in      = byte_total_inc;
                  if (byte_total_inc >= 6'(MAX_BYTES)) begin
                     phase_in           = PH_IDLE;
                     result.packet_done = 1'b1;
                     result.status      = ST_TOO_LONG;
                  end
               end else begin
                  bit_index_in = bit_index_ff + 3'd1;
               end
            end else if (tick_next >= {1'b0, bit_timeout_ff}) begin
               phase_in           = PH_IDLE;
               result.packet_done = 1'b1;
               result.status      = ST_BYTE_TIMEOUT;
            end else begin
               tick_count_in = tick_next[15:0];
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      result.drive_data = (phase_in == PH_ACCEPT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         tick_count_ff      <= '0;
         bit_index_ff       <= '0;
         shift_byte_ff      <= '0;
         byte_total_ff      <= '0;
         crc_all_ff         <= '0;
         crc_before_last_ff <= '0;
      end else if (req_accept) begin
         phase_ff           <= phase_in;
         tick_count_ff      <= tick_count_in;
         bit_index_ff       <= bit_index_in;
         shift_byte_ff      <= shift_byte_in;
         byte_total_ff      <= byte_total_in;
         crc_all_ff         <= crc_all_in;
         crc_before_last_ff <= crc_before_last_in;
      end
   end

   // ---------------- output register and skid ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_take) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (req_accept) begin
            if (out_valid_ff && !rsp_take) skid_valid_ff <= 1'b1;
            else                           out_valid_ff  <= 1'b1;
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) out_ff <= skid_ff;
      end else if (req_accept) begin
         if (out_valid_ff && !rsp_take) skid_ff <= result;
         else                           out_ff  <= result;
      end
   end

   assign rsp_drive_data     = out_ff.drive_data;
   assign rsp_byte_valid     = out_ff.byte_valid;
   assign rsp_byte_value     = out_ff.byte_value;
   assign rsp_packet_done    = out_ff.packet_done;
   assign rsp_status         = out_ff.status;
   assign rsp_payload_length = out_ff.payload_length;

   // ---------------- assertions ----------------
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output entry");

   a_start_enters_accept: assert property (@(posedge clock) disable iff (reset)
      (req_accept && phase_ff == PH_IDLE && req_clock_level) |=> phase_ff == PH_ACCEPT)
      else $error("start not followed by accept phase");

   a_status_needs_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.status == ST_OK || out_ff.packet_done))
      else $error("nonzero status without packet end");

   a_drive_excludes_byte: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.drive_data && out_ff.byte_valid))
      else $error("byte completed during accept drive");

endmodule
